FILE: rtl/qbvg_pkg.sv
// Package for the quad batch vertex generator.
// Holds shared widths, request codes and the sine polynomial coefficients.
// No dependencies.
`timescale 1ns / 1ps
package qbvg_pkg;

	// Operand width of the shared signed multiplier.
	localparam int MUL_W = 33;

	// Indices added to the batch for each quad.
	localparam int INDEX_PER_QUAD = 6;

	// Tiling factor used by fill quads, 1.0 in Q8.8.
	localparam logic [15:0] TILING_ONE = 16'h0100;

	// Seed term of the quarter-wave sine polynomial in Q30.
	localparam logic [31:0] POLY_SEED = 32'd172274;

	// Request codes carried on the mode field.
	typedef enum logic [1:0] {
		MODE_BEGIN   = 2'd0,
		MODE_FILL    = 2'd1,
		MODE_TEXTURE = 2'd2,
		MODE_END     = 2'd3
	} mode_t;

	// Result kinds.
	localparam logic KIND_VERTEX = 1'b0;
	localparam logic KIND_FLUSH  = 1'b1;

	// Horner coefficients of the sine polynomial, highest order first.
	function automatic logic [31:0] poly_coef(input logic [2:0] k);
		logic [31:0] c;
		case (k)
			3'd0:    c = 32'd5026993;
			3'd1:    c = 32'd85569306;
			3'd2:    c = 32'd693598668;
			3'd3:    c = 32'd1686629713;
			default: c = 32'd0;
		endcase
		return c;
	endfunction

endpackage

FILE: rtl/qbvg_mul.sv
// Shared signed multiplier with a registered product.
// Depends on qbvg_pkg for the operand width.
`timescale 1ns / 1ps
module qbvg_mul import qbvg_pkg::*; (
	input  logic                        clk,
	input  logic signed [MUL_W-1:0]     op_a,
	input  logic signed [MUL_W-1:0]     op_b,
	output logic signed [2*MUL_W-1:0]   prod
);

	// One product per cycle, registered before anyone uses it.
	always_ff @(posedge clk) begin
		prod <= op_a * op_b;
	end

endmodule

FILE: rtl/quad_batch_vertex_generator.sv
// Top level of the quad batch vertex generator: sequencer, slot table and result register.
// Depends on qbvg_pkg and qbvg_mul.
`timescale 1ns / 1ps
// A fill or textured quad request computes sine and cosine with six products each and
// the four scaled sizes with four more, all through one shared multiplier, then passes
// each vertex through a calculate and an emit state. A textured request first compares
// the slots in use, and on a miss ends the search and allocates a slot. A flush emits
// one entry per slot in use, and begin scene resets the batch without leaving idle. The
// block holds stall high on the request channel while it works and takes a configuration
// write only while idle. Results wait in an output register, so a stalled consumer only
// holds the sequencer at the next result.
module quad_batch_vertex_generator import qbvg_pkg::*; #(
	parameter int MAX_QUADS = 8192,
	parameter int TEX_SLOTS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	// Configuration write channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [13:0]        cfg_data,
	// Request channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         mode,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] size_x,
	input  logic signed [31:0] size_y,
	input  logic [15:0]        rotation,
	input  logic [31:0]        color,
	input  logic [31:0]        texture_id,
	input  logic [15:0]        tiling,
	// Result channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic               kind,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	output logic [31:0]        out_color,
	output logic [1:0]         corner,
	output logic [3:0]         tex_slot,
	output logic [15:0]        out_tiling,
	output logic [31:0]        bound_texture,
	output logic [15:0]        index_total,
	output logic [4:0]         slot_total,
	output logic               last
);

	localparam int SW = $clog2(TEX_SLOTS);
	localparam int CW = $clog2(TEX_SLOTS + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FLUSH,
		ST_SEARCH,
		ST_ALLOC,
		ST_TRIG,
		ST_SCALE,
		ST_CALC,
		ST_EMIT
	} state_t;

	state_t state_q;
	state_t ret_q;
	logic   end_q;
	logic   renew_q;
	logic   textured_q;

	// Captured request
	logic signed [31:0] pos_x_q, pos_y_q, pos_z_q, size_x_q, size_y_q;
	logic [15:0]        rot_q, tiling_q;
	logic [31:0]        color_q, tex_id_q;

	// Batch state
	logic [13:0]   limit_q;
	logic [15:0]   index_q;
	logic [CW-1:0] slots_q;
	logic [31:0]   slot_table [TEX_SLOTS];
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] slot_q;

	// Sequencer state of the shared multiplier
	logic        half_q;
	logic [2:0]  uop_q;
	logic        phase_q;
	logic [31:0] t2_q;
	logic [31:0] p_q;
	logic signed [17:0] sin_q, cos_q;
	logic signed [48:0] a_q, b_q, c_q, d_q;
	logic [1:0]  corner_q;
	logic [31:0] dx_q, dy_q;

	logic out_valid_q;

	// Effective limit and the batch-full threshold in indices.
	logic [13:0] eff_lim;
	logic [16:0] thr;
	logic        batch_full;
	always_comb begin
		eff_lim = limit_q;
		if (limit_q == 14'd0) begin
			eff_lim = 14'd1;
		end else if (limit_q > 14'(MAX_QUADS)) begin
			eff_lim = 14'(MAX_QUADS);
		end
		thr        = 17'(eff_lim) * 17'(INDEX_PER_QUAD);
		batch_full = {1'b0, index_q} >= thr;
	end

	// Quarter-wave argument of the angle in work.
	logic [15:0] ang;
	logic [14:0] qx;
	logic [30:0] t_val;
	always_comb begin
		ang = phase_q ? (rot_q + 16'h4000) : rot_q;
		qx  = {1'b0, ang[13:0]};
		if (ang[14]) begin
			qx = 15'h4000 - {1'b0, ang[13:0]};
		end
		t_val = {qx, 16'b0};
	end

	// Operand selection for the shared multiplier.
	logic signed [MUL_W-1:0]   op_a, op_b;
	logic signed [2*MUL_W-1:0] prod;
	always_comb begin
		op_a = '0;
		op_b = '0;
		if (state_q == ST_TRIG) begin
			if (uop_q == 3'd0) begin
				op_a = MUL_W'(t_val);
				op_b = MUL_W'(t_val);
			end else if (uop_q == 3'd5) begin
				op_a = MUL_W'(t_val);
				op_b = {1'b0, p_q};
			end else begin
				op_a = {1'b0, t2_q};
				op_b = {1'b0, p_q};
			end
		end else begin
			op_a = uop_q[1] ? MUL_W'(size_y_q) : MUL_W'(size_x_q);
			op_b = uop_q[0] ? MUL_W'(sin_q) : MUL_W'(cos_q);
		end
	end

	qbvg_mul u_mul (
		.clk  (clk),
		.op_a (op_a),
		.op_b (op_b),
		.prod (prod)
	);

	// Rounded and clamped sine from the final product.
	logic [35:0]        s_raw;
	logic [21:0]        s_rnd;
	logic [16:0]        s_mag;
	logic signed [17:0] s_signed;
	always_comb begin
		s_raw = prod[65:30];
		s_rnd = 22'((s_raw + 36'd8192) >> 14);
		s_mag = (s_rnd > 22'd65536) ? 17'd65536 : s_rnd[16:0];
		s_signed = ang[15] ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});
	end

	// Corner offsets: half-size scaling folded into the shift by 17.
	logic               sgx, sgy;
	logic signed [50:0] sum_x, sum_y;
	always_comb begin
		sgx   = (corner_q == 2'd1) || (corner_q == 2'd2);
		sgy   = corner_q[1];
		sum_x = (sgx ? 51'(a_q) : -51'(a_q)) - (sgy ? 51'(d_q) : -51'(d_q)) + 51'sd65536;
		sum_y = (sgx ? 51'(b_q) : -51'(b_q)) + (sgy ? 51'(c_q) : -51'(c_q)) + 51'sd65536;
	end

	logic out_load;
	assign out_load  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	logic [31:0] table_rd;
	assign table_rd = (cnt_q == '0) ? 32'd0 : slot_table[cnt_q[SW-1:0]];

	// Slot table: written on allocation, no reset.
	always_ff @(posedge clk) begin
		if (state_q == ST_ALLOC) begin
			slot_table[slots_q[SW-1:0]] <= tex_id_q;
		end
	end

	// Main sequencer with its registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ret_q       <= ST_IDLE;
			end_q       <= 1'b0;
			renew_q     <= 1'b0;
			textured_q  <= 1'b0;
			limit_q     <= 14'd8192;
			index_q     <= '0;
			slots_q     <= CW'(1);
			cnt_q       <= '0;
			slot_q      <= '0;
			half_q      <= 1'b0;
			uop_q       <= '0;
			phase_q     <= 1'b0;
			corner_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cfg_valid) begin
						limit_q <= cfg_data;
					end
					if (in_valid) begin
						pos_x_q    <= pos_x;
						pos_y_q    <= pos_y;
						pos_z_q    <= pos_z;
						size_x_q   <= size_x;
						size_y_q   <= size_y;
						rot_q      <= rotation;
						color_q    <= color;
						tex_id_q   <= texture_id;
						tiling_q   <= tiling;
						textured_q <= (mode == MODE_TEXTURE);
						cnt_q      <= '0;
						slot_q     <= '0;
						uop_q      <= '0;
						half_q     <= 1'b0;
						phase_q    <= 1'b0;
						corner_q   <= '0;
						end_q      <= (mode == MODE_END);
						unique case (mode_t'(mode))
							MODE_BEGIN: begin
								index_q <= '0;
								slots_q <= CW'(1);
							end
							MODE_END: begin
								if (index_q != '0) begin
									state_q <= ST_FLUSH;
									renew_q <= 1'b0;
									ret_q   <= ST_IDLE;
								end
							end
							default: begin
								if (batch_full) begin
									state_q <= ST_FLUSH;
									renew_q <= 1'b1;
									ret_q   <= (mode == MODE_TEXTURE) ? ST_SEARCH : ST_TRIG;
								end else begin
									state_q <= (mode == MODE_TEXTURE) ? ST_SEARCH : ST_TRIG;
								end
								// A flush starts at slot zero; a search starts at slot one.
								cnt_q <= (!batch_full && mode == MODE_TEXTURE) ? CW'(1) : '0;
							end
						endcase
					end
				end
				ST_FLUSH: begin
					if (out_load) begin
						out_valid_q   <= 1'b1;
						kind          <= KIND_FLUSH;
						out_x         <= '0;
						out_y         <= '0;
						out_z         <= '0;
						out_color     <= '0;
						corner        <= '0;
						out_tiling    <= '0;
						tex_slot      <= 4'(cnt_q);
						bound_texture <= table_rd;
						index_total   <= index_q;
						slot_total    <= 5'(slots_q);
						last          <= end_q && (cnt_q == slots_q - CW'(1));
						if (cnt_q == slots_q - CW'(1)) begin
							state_q <= ret_q;
							cnt_q   <= CW'(1);
							if (renew_q) begin
								index_q <= '0;
								slots_q <= CW'(1);
							end
						end else begin
							cnt_q <= cnt_q + CW'(1);
						end
					end
				end
				ST_SEARCH: begin
					// One slot compared per cycle.
					if (cnt_q >= slots_q) begin
						if (slots_q >= CW'(TEX_SLOTS)) begin
							state_q <= ST_FLUSH;
							renew_q <= 1'b1;
							ret_q   <= ST_ALLOC;
							cnt_q   <= '0;
						end else begin
							state_q <= ST_ALLOC;
						end
					end else if (table_rd == tex_id_q) begin
						slot_q  <= cnt_q;
						state_q <= ST_TRIG;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_ALLOC: begin
					slot_q  <= slots_q;
					slots_q <= slots_q + CW'(1);
					state_q <= ST_TRIG;
				end
				ST_TRIG: begin
					half_q <= !half_q;
					if (half_q) begin
						uop_q <= uop_q + 3'd1;
						if (uop_q == 3'd0) begin
							t2_q <= prod[61:30];
							p_q  <= POLY_SEED;
						end else if (uop_q == 3'd5) begin
							uop_q <= '0;
							if (phase_q) begin
								cos_q   <= s_signed;
								state_q <= ST_SCALE;
							end else begin
								sin_q   <= s_signed;
								phase_q <= 1'b1;
							end
						end else begin
							p_q <= poly_coef(uop_q - 3'd1) - prod[61:30];
						end
					end
				end
				ST_SCALE: begin
					half_q <= !half_q;
					if (half_q) begin
						uop_q <= uop_q + 3'd1;
						case (uop_q[1:0])
							2'd0:    a_q <= prod[48:0];
							2'd1:    b_q <= prod[48:0];
							2'd2:    c_q <= prod[48:0];
							default: d_q <= prod[48:0];
						endcase
						if (uop_q[1:0] == 2'd3) begin
							state_q <= ST_CALC;
						end
					end
				end
				ST_CALC: begin
					dx_q    <= sum_x[48:17];
					dy_q    <= sum_y[48:17];
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_load) begin
						out_valid_q   <= 1'b1;
						kind          <= KIND_VERTEX;
						out_x         <= pos_x_q + $signed(dx_q);
						out_y         <= pos_y_q + $signed(dy_q);
						out_z         <= pos_z_q;
						out_color     <= color_q;
						corner        <= corner_q;
						tex_slot      <= 4'(slot_q);
						out_tiling    <= textured_q ? tiling_q : TILING_ONE;
						bound_texture <= '0;
						index_total   <= '0;
						slot_total    <= '0;
						last          <= (corner_q == 2'd3);
						if (corner_q == 2'd3) begin
							index_q <= index_q + 16'(INDEX_PER_QUAD);
							state_q <= ST_IDLE;
						end else begin
							corner_q <= corner_q + 2'd1;
							state_q  <= ST_CALC;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	// The slot count stays between one and the table depth.
	a_slots_range: assert property (@(posedge clk) disable iff (!arst_n)
		(slots_q != '0) && (slots_q <= CW'(TEX_SLOTS)))
		else $error("slot count out of range");

	// The search never looks at the reserved fill slot.
	a_search_from_one: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> (cnt_q != '0))
		else $error("search reached slot zero");

	// A flush entry carries no vertex corner or position.
	a_flush_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && kind == KIND_FLUSH) |-> (corner == 2'd0 && out_x == 32'sd0))
		else $error("flush entry carries vertex data");

	// A vertex emit always advances the batch index count at the final corner.
	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && out_load && corner_q == 2'd3)
		|=> (index_q == $past(index_q) + 16'(INDEX_PER_QUAD)))
		else $error("index count not advanced");
`endif

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the quad batch vertex generator.
// Drives draw requests and batch limit writes, predicts every vertex and flush entry.
// Depends on qbvg_pkg and quad_batch_vertex_generator.
`timescale 1ns / 1ps
module testbench;
	import qbvg_pkg::*;

	// One draw request as it stands on the request channel.
	typedef struct {
		logic [1:0]         mode;
		logic signed [31:0] px, py, pz, sx, sy;
		logic [15:0]        rot;
		logic [31:0]        col, tid;
		logic [15:0]        til;
	} draw_req_t;

	// One vertex or flush entry as it stands on the result channel.
	typedef struct {
		logic        knd;
		logic [31:0] x, y, z, col;
		logic [1:0]  cor;
		logic [3:0]  slot;
		logic [15:0] til;
		logic [31:0] btex;
		logic [15:0] itot;
		logic [4:0]  stot;
		logic        lst;
	} vtx_result_t;

	// Directed row: a request, an optional limit write before it, the result count.
	typedef struct {
		draw_req_t req;
		int        limit_wr;
		int        n_results;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic cfg_valid, cfg_ready;
	logic [13:0] cfg_data;
	logic in_valid, in_stall;
	logic [1:0] mode;
	logic signed [31:0] pos_x, pos_y, pos_z, size_x, size_y;
	logic [15:0] rotation, tiling;
	logic [31:0] color, texture_id;
	logic out_valid, out_stall;
	logic kind;
	logic signed [31:0] out_x, out_y, out_z;
	logic [31:0] out_color;
	logic [1:0] corner;
	logic [3:0] tex_slot;
	logic [15:0] out_tiling;
	logic [31:0] bound_texture;
	logic [15:0] index_total;
	logic [4:0] slot_total;
	logic last;

	quad_batch_vertex_generator u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .mode(mode),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .size_x(size_x), .size_y(size_y),
		.rotation(rotation), .color(color), .texture_id(texture_id), .tiling(tiling),
		.out_valid(out_valid), .out_stall(out_stall), .kind(kind),
		.out_x(out_x), .out_y(out_y), .out_z(out_z), .out_color(out_color),
		.corner(corner), .tex_slot(tex_slot), .out_tiling(out_tiling),
		.bound_texture(bound_texture), .index_total(index_total),
		.slot_total(slot_total), .last(last)
	);

	// Mirror of the block's batch state.
	logic [13:0] quad_limit;
	logic [15:0] batch_indices;
	logic [4:0]  slots_used;
	logic [31:0] bound_ids [16];

	vtx_result_t pending_vertices [$];
	int mismatches = 0;
	int unexpected = 0;
	int n_sent = 0;
	int n_seen = 0;
	int n_flush = 0;
	int n_cfg = 0;
	bit sender_done = 0;
	int stall_mode = 0;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Sine over a quarter wave, angle 0..16384, result Q16 clamped to 0..65536.
	function automatic longint quarter_wave_sin(input logic [15:0] x);
		longint unsigned t, t2, p, s;
		t  = longint'(x) << 16;
		t2 = (t * t) >> 30;
		p  = longint'(POLY_SEED);
		p  = 64'd5026993 - ((t2 * p) >> 30);
		p  = 64'd85569306 - ((t2 * p) >> 30);
		p  = 64'd693598668 - ((t2 * p) >> 30);
		p  = 64'd1686629713 - ((t2 * p) >> 30);
		s  = (t * p) >> 30;
		s  = (s + 64'd8192) >> 14;
		if (s > 64'd65536)
			s = 64'd65536;
		return longint'(s);
	endfunction

	// Full-turn sine from the quarter wave by symmetry.
	function automatic longint angle_sin(input logic [15:0] a);
		logic [15:0] x;
		longint s;
		x = {2'b00, a[13:0]};
		if (a[14])
			x = 16'h4000 - x;
		s = quarter_wave_sin(x);
		return a[15] ? -s : s;
	endfunction

	// Flush entries, one per slot in use.
	task automatic queue_flush(input bit mark_last);
		vtx_result_t e;
		for (int i = 0; i < slots_used && i < 16; i++) begin
			e = '{default: '0};
			e.knd  = KIND_FLUSH;
			e.slot = i[3:0];
			e.btex = bound_ids[i];
			e.itot = batch_indices;
			e.stot = slots_used;
			e.lst  = mark_last && (i == slots_used - 1);
			pending_vertices.push_back(e);
			n_flush++;
		end
	endtask

	// Works out the results of one accepted request and updates the batch state.
	task automatic predict_request(input draw_req_t r, output int n);
		int before_n;
		int eff;
		logic [3:0] slot;
		logic [15:0] til;
		longint sn, cs, lx, ly, dx, dy;
		vtx_result_t e;
		before_n = pending_vertices.size();
		eff = (quad_limit == 0) ? 1 : (quad_limit > 8192 ? 8192 : quad_limit);
		case (mode_t'(r.mode))
			MODE_BEGIN: begin
				batch_indices = '0;
				slots_used = 5'd1;
			end
			MODE_END: begin
				if (batch_indices != 0)
					queue_flush(1'b1);
			end
			default: begin
				slot = '0;
				til = TILING_ONE;
				if (batch_indices >= INDEX_PER_QUAD * eff) begin
					queue_flush(1'b0);
					batch_indices = '0;
					slots_used = 5'd1;
				end
				if (mode_t'(r.mode) == MODE_TEXTURE) begin
					for (int i = 1; i < slots_used && i < 16; i++)
						if (slot == 0 && bound_ids[i] == r.tid)
							slot = i[3:0];
					if (slot == 0) begin
						// Table full on a miss: flush, then allocate in a fresh batch.
						if (slots_used >= 16) begin
							queue_flush(1'b0);
							batch_indices = '0;
							slots_used = 5'd1;
						end
						slot = slots_used[3:0];
						bound_ids[slot] = r.tid;
						slots_used++;
					end
					til = r.til;
				end
				sn = angle_sin(r.rot);
				cs = angle_sin(r.rot + 16'h4000);
				for (int c = 0; c < 4; c++) begin
					lx = (c == 1 || c == 2) ? longint'(r.sx) : -longint'(r.sx);
					ly = (c >= 2) ? longint'(r.sy) : -longint'(r.sy);
					dx = (lx * cs - ly * sn + 65536) >>> 17;
					dy = (lx * sn + ly * cs + 65536) >>> 17;
					e = '{default: '0};
					e.knd  = KIND_VERTEX;
					e.x    = r.px + dx[31:0];
					e.y    = r.py + dy[31:0];
					e.z    = r.pz;
					e.col  = r.col;
					e.cor  = c[1:0];
					e.slot = slot;
					e.til  = til;
					e.lst  = (c == 3);
					pending_vertices.push_back(e);
				end
				batch_indices = batch_indices + INDEX_PER_QUAD;
			end
		endcase
		n = pending_vertices.size() - before_n;
	endtask

	// Sends one request, holding it until the block takes it.
	task automatic send_request(input draw_req_t r, output int n);
		@(negedge clk);
		mode = r.mode; pos_x = r.px; pos_y = r.py; pos_z = r.pz;
		size_x = r.sx; size_y = r.sy; rotation = r.rot; color = r.col;
		texture_id = r.tid; tiling = r.til;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		predict_request(r, n);
		n_sent++;
	endtask

	// Drops valid for a random gap, or keeps streaming if the burst goes on.
	task automatic sender_gap(input int gap);
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Waits until every expected result is in, then lets trailing work settle.
	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_vertices.size() != 0) @(negedge clk);
		repeat (64) @(negedge clk);
	endtask

	// Writes the batch limit while the block is idle.
	task automatic write_limit(input logic [13:0] v);
		wait_drained();
		cfg_data = v;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		quad_limit = v;
		n_cfg++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic draw_req_t mk_req(input mode_t m, input logic [31:0] px, py,
		input logic [31:0] sx, sy, input logic [15:0] rot, input logic [31:0] tid,
		input logic [15:0] til);
		draw_req_t r;
		r.mode = m; r.px = px; r.py = py; r.pz = px ^ 32'h5A5A_0F0F;
		r.sx = sx; r.sy = sy; r.rot = rot; r.col = ~tid ^ px;
		r.tid = tid; r.til = til;
		return r;
	endfunction

	function automatic dir_row_t mk_row(input draw_req_t r, input int lw, input int n);
		dir_row_t d;
		d.req = r; d.limit_wr = lw; d.n_results = n;
		return d;
	endfunction

	// Random quad: mostly textured from a small id pool, small sizes mostly.
	function automatic draw_req_t rand_quad(input logic [31:0] pool [32], input int pool_n);
		draw_req_t r;
		r.mode = ($urandom_range(0, 9) < 7) ? MODE_TEXTURE : MODE_FILL;
		r.px = $urandom; r.py = $urandom; r.pz = $urandom;
		if ($urandom_range(0, 3) == 0) begin
			r.sx = $urandom; r.sy = $urandom;
		end else begin
			r.sx = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
			r.sy = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
		end
		r.rot = $urandom; r.col = $urandom;
		r.tid = ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, pool_n - 1)];
		r.til = $urandom;
		return r;
	endfunction

	// Result monitor: each accepted result against the oldest expectation.
	always @(posedge clk) begin
		vtx_result_t e;
		string bad;
		if (arst_n && out_valid && !out_stall) begin
			n_seen++;
			if (pending_vertices.size() == 0) begin
				unexpected++;
				if (mismatches + unexpected <= 10)
					$display("%0t: result with nothing expected, kind %0b", $realtime, kind);
			end else begin
				e = pending_vertices.pop_front();
				bad = "";
				if (kind !== e.knd) bad = {bad, " kind"};
				if (out_x !== e.x) bad = {bad, " out_x"};
				if (out_y !== e.y) bad = {bad, " out_y"};
				if (out_z !== e.z) bad = {bad, " out_z"};
				if (out_color !== e.col) bad = {bad, " out_color"};
				if (corner !== e.cor) bad = {bad, " corner"};
				if (tex_slot !== e.slot) bad = {bad, " tex_slot"};
				if (out_tiling !== e.til) bad = {bad, " out_tiling"};
				if (bound_texture !== e.btex) bad = {bad, " bound_texture"};
				if (index_total !== e.itot) bad = {bad, " index_total"};
				if (slot_total !== e.stot) bad = {bad, " slot_total"};
				if (last !== e.lst) bad = {bad, " last"};
				if (bad != "") begin
					mismatches++;
					if (mismatches + unexpected <= 10)
						$display({"%0t: mismatch in%s\n  expected k%0b x%h y%h z%h c%h ",
							"cor%0d s%0d t%h b%h i%0d n%0d l%0b\n  actual   k%0b x%h y%h z%h ",
							"c%h cor%0d s%0d t%h b%h i%0d n%0d l%0b"}, $realtime, bad,
							e.knd, e.x, e.y, e.z, e.col, e.cor, e.slot, e.til, e.btex,
							e.itot, e.stot, e.lst, kind, out_x, out_y, out_z, out_color,
							corner, tex_slot, out_tiling, bound_texture, index_total,
							slot_total, last);
				end
			end
		end
	end

	// Receiver stall pattern: free running, light random, or long holds.
	initial begin
		int hold;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 199) == 0)
				stall_mode = $urandom_range(0, 2);
			case (stall_mode)
				0: out_stall = 1'b0;
				1: out_stall = ($urandom_range(0, 9) < 3);
				default: begin
					hold = $urandom_range(1, 20);
					out_stall = 1'b1;
					repeat (hold - 1) @(negedge clk);
					@(negedge clk);
					out_stall = 1'b0;
				end
			endcase
		end
	end

	// Stimulus.
	initial begin
		dir_row_t rows [$];
		logic [31:0] pool [32];
		int limits [6] = '{3, 1, 0, 16383, 2, 8192};
		int pools [6] = '{5, 3, 24, 20, 8, 17};
		int n, burst;
		draw_req_t r;

		arst_n = 1'b0;
		cfg_valid = 1'b0; cfg_data = '0;
		in_valid = 1'b0; mode = '0;
		pos_x = '0; pos_y = '0; pos_z = '0; size_x = '0; size_y = '0;
		rotation = '0; color = '0; texture_id = '0; tiling = '0;
		quad_limit = 14'd8192; batch_indices = '0; slots_used = 5'd1;
		foreach (bound_ids[i]) bound_ids[i] = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// Directed part: empty scene ends, rotations, extremes, texture hits and
		// misses, repeated flush, and the batch limit at one, zero and beyond range.
		rows.push_back(mk_row(mk_req(MODE_END, 0, 0, 0, 0, 0, 0, 0), -1, 0));
		rows.push_back(mk_row(mk_req(MODE_BEGIN, 0, 0, 0, 0, 0, 0, 0), -1, 0));
		rows.push_back(mk_row(mk_req(MODE_FILL, 0, 0, 32'h1_0000, 32'h1_0000, 0, 0, 0), -1, 4));
		rows.push_back(mk_row(mk_req(MODE_FILL, 32'h10_0000, 32'hFFF0_0000, 32'h2_0000,
			32'h1_0000, 16'h4000, 1, 0), -1, 4));
		rows.push_back(mk_row(mk_req(MODE_FILL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF), -1, 4));
		rows.push_back(mk_row(mk_req(MODE_FILL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 16'h8000, 0, 0), -1, 4));
		rows.push_back(mk_row(mk_req(MODE_TEXTURE, 32'h3_0000, 32'h4_0000, 32'h1_8000,
			32'h0_8000, 16'h2000, 0, 0), -1, 4));
		rows.push_back(mk_row(mk_req(MODE_TEXTURE, 32'hFFFF_0000, 1, 32'hFFFF_8000,
			32'h0_4000, 16'hC000, 32'hFFFF_FFFF, 16'hFFFF), -1, 4));
		rows.push_back(mk_row(mk_req(MODE_TEXTURE, 5, 6, 32'h5_0000, 32'h3_0000, 16'h6000,
			0, 16'h0200), -1, 4));
		rows.push_back(mk_row(mk_req(MODE_END, 0, 0, 0, 0, 0, 0, 0), -1, 3));
		rows.push_back(mk_row(mk_req(MODE_END, 0, 0, 0, 0, 0, 0, 0), -1, 3));
		rows.push_back(mk_row(mk_req(MODE_BEGIN, 0, 0, 0, 0, 0, 0, 0), -1, 0));
		rows.push_back(mk_row(mk_req(MODE_END, 0, 0, 0, 0, 0, 0, 0), -1, 0));
		rows.push_back(mk_row(mk_req(MODE_TEXTURE, 32'h1234_5678, 32'h8765_4321, 32'h4_0000,
			32'h2_0000, 16'h1000, 32'h5A5A_5A5A, 16'h0180), -1, 4));
		rows.push_back(mk_row(mk_req(MODE_FILL, 7, 9, 32'h1_0000, 32'h1_0000, 16'hC000,
			32'hA5A5_A5A5, 0), -1, 4));
		rows.push_back(mk_row(mk_req(MODE_FILL, 0, 0, 32'h1_0000, 32'h1_0000, 0, 2, 0), 1, 6));
		rows.push_back(mk_row(mk_req(MODE_FILL, 1, 1, 32'h1_0000, 32'h1_0000, 0, 3, 0), -1, 5));
		rows.push_back(mk_row(mk_req(MODE_TEXTURE, 1, 1, 32'h1_0000, 32'h1_0000, 0, 4, 0), 0, 5));
		rows.push_back(mk_row(mk_req(MODE_FILL, 2, 2, 32'h1_0000, 32'h1_0000, 0, 5, 0), 16383, 4));
		rows.push_back(mk_row(mk_req(MODE_END, 0, 0, 0, 0, 0, 0, 0), -1, 2));
		foreach (rows[i]) begin
			if (rows[i].limit_wr >= 0)
				write_limit(rows[i].limit_wr[13:0]);
			send_request(rows[i].req, n);
			if (n != rows[i].n_results) begin
				mismatches++;
				$display("directed row %0d: %0d results predicted, %0d listed", i, n,
					rows[i].n_results);
			end
		end

		// Random part: each phase a fresh limit and a scene of quads with random content,
		// with some noise requests thrown in.
		foreach (limits[p]) begin
			write_limit(limits[p][13:0]);
			foreach (pool[i]) pool[i] = $urandom;
			burst = $urandom_range(1, 6);
			r = mk_req(MODE_BEGIN, 0, 0, 0, 0, 0, 0, 0);
			send_request(r, n);
			for (int k = 0; k < 16; k++) begin
				if ($urandom_range(0, 9) == 0) begin
					r = rand_quad(pool, pools[p]);
					r.mode = $urandom;
				end else
					r = rand_quad(pool, pools[p]);
				if (--burst == 0) begin
					sender_gap($urandom_range(1, 30));
					burst = $urandom_range(1, 8);
				end
				// Once per phase the sender holds off until the block is drained.
				if (k == 8)
					wait_drained();
				send_request(r, n);
			end
			r = mk_req(MODE_END, 0, 0, 0, 0, 0, 0, 0);
			send_request(r, n);
		end
		@(negedge clk);
		in_valid = 1'b0;
		sender_done = 1'b1;
	end

	// End of run.
	initial begin
		wait (sender_done);
		while (pending_vertices.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		$display("Sent %0d requests with %0d limit writes; checked %0d results, %0d of them",
			n_sent, n_cfg, n_seen, n_flush);
		$display("flush entries, with %0d mismatches and %0d unexpected results.",
			mismatches, unexpected);
		if (mismatches == 0 && unexpected == 0 && pending_vertices.size() == 0)
			$display("[quad_batch_vertex_generator] OK");
		else
			$display("[quad_batch_vertex_generator] ERROR");
		$finish;
	end

	// Watchdog.
	initial begin
		#2000000;
		$display("Timeout with %0d results still expected.", pending_vertices.size());
		$display("[quad_batch_vertex_generator] ERROR");
		$finish;
	end

endmodule
